>>> hdl/rau_pkg.sv
`default_nettype none
package rau_pkg;

  localparam int OPW       = 16;
  localparam int VW        = 2 * OPW;
  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 32;
  localparam int FUNC_W    = 3;
  localparam int CMP_W     = 2;

  localparam logic [FUNC_W-1:0] F_ADD  = 3'd0;
  localparam logic [FUNC_W-1:0] F_SUB  = 3'd1;
  localparam logic [FUNC_W-1:0] F_DIV  = 3'd2;
  localparam logic [FUNC_W-1:0] F_MUL  = 3'd3;
  localparam logic [FUNC_W-1:0] F_CMP  = 3'd4;
  localparam logic [FUNC_W-1:0] F_SIMP = 3'd5;

  localparam logic [CMP_W-1:0] C_EQ  = 2'd0;
  localparam logic [CMP_W-1:0] C_AGT = 2'd1;
  localparam logic [CMP_W-1:0] C_BGT = 2'd2;

  typedef logic [OPW-1:0] opnd_t;
  typedef logic [VW-1:0]  val_t;

  function automatic opnd_t mag_of(input opnd_t x);
    mag_of = x[OPW-1] ? (~x + 1'b1) : x;
  endfunction

endpackage
`default_nettype wire

>>> hdl/rau_mul.sv
`default_nettype none
module rau_mul import rau_pkg::*; (
  input  wire   clk,
  input  opnd_t a,
  input  opnd_t b,
  output val_t  p
);

  val_t p_r;

  always_ff @(posedge clk) begin
    p_r <= {{(VW-OPW){1'b0}}, a} * {{(VW-OPW){1'b0}}, b};
  end

  assign p = p_r;

endmodule
`default_nettype wire

>>> hdl/rau_gcd.sv
`default_nettype none
module rau_gcd import rau_pkg::*; (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   start,
  input  val_t  a,
  input  val_t  b,
  output logic  done,
  output val_t  g
);

  localparam int KW = $clog2(VW);

  logic          busy_r;
  logic          done_r;
  val_t          a_r, a_nxt;
  val_t          b_r, b_nxt;
  logic [KW-1:0] k_r, k_nxt;
  val_t          g_r;

  // binary gcd, b stays nonzero; common factors of two counted in k
  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    k_nxt = k_r;
    case ({a_r[0], b_r[0]})
      2'b00: begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + 1'b1;
      end
      2'b01: a_nxt = a_r >> 1;
      2'b10: b_nxt = b_r >> 1;
      default: begin
        if (a_r >= b_r) begin
          a_nxt = (a_r - b_r) >> 1;
        end else begin
          b_nxt = (b_r - a_r) >> 1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && (a_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (a_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      k_r <= '0;
    end else if (busy_r) begin
      if (a_r == '0) begin
        g_r <= b_r << k_r;
      end else begin
        a_r <= a_nxt;
        b_r <= b_nxt;
        k_r <= k_nxt;
      end
    end
  end

  assign done = done_r;
  assign g    = g_r;

endmodule
`default_nettype wire

>>> hdl/rau_div.sv
`default_nettype none
module rau_div import rau_pkg::*; (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   start,
  input  val_t  dividend,
  input  val_t  divisor,
  output logic  done,
  output val_t  quotient
);

  localparam int CW = $clog2(VW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  val_t          q_r, q_nxt;
  val_t          rem_r, rem_nxt;
  val_t          dvs_r;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial   = {rem_r, q_r[VW-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[VW-1:0] : trial[VW-1:0];
    q_nxt   = {q_r[VW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CW'(VW - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(VW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

>>> hdl/rational_arith_unit.sv
`default_nettype none
// Signed fraction arithmetic: add, subtract, divide, multiply, compare and
// simplify on two 16-bit fractions, each fraction result reduced by the gcd
// of its magnitudes. A word is taken when start is high and busy is low; busy
// then stays high until the last result has been issued. Every result is
// marked on the out_ ports by out_strobe high for exactly one cycle and
// cannot be stalled; simplify issues two results, the second with out_last
// set. An item runs through the three products on the one shared
// multiplier, forming the fraction, the binary gcd unit, the bit-serial
// divider that divides numerator and denominator by the gcd, and issuing the
// result. Simplify skips the products and runs the gcd and divider twice.
// Compare and zero denominators skip the gcd and divider; an unknown code
// skips the products too, and simplify with both denominators zero skips
// the gcd and divider for both results.
module rational_arith_unit import rau_pkg::*; (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire  [FUNC_W-1:0]           in_func,
  input  wire  signed [OPW-1:0]       in_num_a,
  input  wire  signed [OPW-1:0]       in_den_a,
  input  wire  signed [OPW-1:0]       in_num_b,
  input  wire  signed [OPW-1:0]       in_den_b,
  output logic                        out_strobe,
  output logic signed [RES_NUM_W-1:0] out_res_num,
  output logic signed [RES_DEN_W-1:0] out_res_den,
  output logic [CMP_W-1:0]            out_cmp_code,
  output logic                        out_error,
  output logic                        out_last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_FORM = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DIVN = 3'd4;
  localparam logic [2:0] S_DIVD = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [FUNC_W-1:0] func_r;
  opnd_t             na_r, da_r, nb_r, db_r;
  logic [1:0]        mcnt_r;
  val_t              p0_r, p1_r, p2_r;
  logic              pass_r;
  val_t              nmag_r, dmag_r;
  logic              nneg_r, dneg_r;
  logic              err_r;
  logic [CMP_W-1:0]  cmp_r;

  logic                 out_strobe_r;
  logic [RES_NUM_W-1:0] out_res_num_r;
  logic [RES_DEN_W-1:0] out_res_den_r;
  logic [CMP_W-1:0]     out_cmp_code_r;
  logic                 out_error_r;
  logic                 out_last_r;

  opnd_t     mag_na, mag_da, mag_nb, mag_db;
  opnd_t     mul_a, mul_b;
  val_t      mul_p;
  logic      gcd_start, gcd_done, div_start, div_done;
  val_t      gcd_g, div_q, div_dividend;

  logic              s0, s1, s1_raw;
  val_t              sum_mag;
  logic              sum_neg;
  val_t              num_mag, den_mag;
  logic              num_neg, den_neg;
  logic              form_err;
  logic [CMP_W-1:0]  cmp_calc;
  logic              is_last;
  logic [VW:0]       num_ext, num_fld;
  val_t              den_fld;

  assign mag_na = mag_of(na_r);
  assign mag_da = mag_of(da_r);
  assign mag_nb = mag_of(nb_r);
  assign mag_db = mag_of(db_r);

  // multiplier operands: pair 0 is the first numerator product, 1 the
  // cross product, 2 the denominator product
  always_comb begin
    case (mcnt_r)
      2'd0: begin
        mul_a = mag_na;
        mul_b = (func_r == F_MUL) ? mag_nb : mag_db;
      end
      2'd1: begin
        mul_a = mag_nb;
        mul_b = mag_da;
      end
      default: begin
        mul_a = mag_da;
        mul_b = (func_r == F_DIV) ? mag_nb : mag_db;
      end
    endcase
  end

  rau_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  rau_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .a     (num_mag),
    .b     (den_mag),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  assign div_dividend = (state_r == S_GCD) ? nmag_r : dmag_r;

  rau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (gcd_g),
    .done     (div_done),
    .quotient (div_q)
  );

  // signed combination of the products and the compare code
  always_comb begin
    s0 = ((func_r == F_MUL) ? (na_r[OPW-1] ^ nb_r[OPW-1]) : (na_r[OPW-1] ^ db_r[OPW-1]))
         & (p0_r != '0);
    s1_raw = (nb_r[OPW-1] ^ da_r[OPW-1]) & (p1_r != '0);
    s1     = (nb_r[OPW-1] ^ da_r[OPW-1] ^ (func_r == F_SUB)) & (p1_r != '0);
    if (s0 == s1) begin
      sum_mag = p0_r + p1_r;
      sum_neg = s0;
    end else if (p0_r >= p1_r) begin
      sum_mag = p0_r - p1_r;
      sum_neg = s0;
    end else begin
      sum_mag = p1_r - p0_r;
      sum_neg = s1;
    end
    sum_neg = sum_neg & (sum_mag != '0);

    if (s0 != s1_raw) begin
      cmp_calc = s0 ? C_BGT : C_AGT;
    end else if (p0_r == p1_r) begin
      cmp_calc = C_EQ;
    end else if (p0_r > p1_r) begin
      cmp_calc = s0 ? C_BGT : C_AGT;
    end else begin
      cmp_calc = s0 ? C_AGT : C_BGT;
    end
    if ((da_r[OPW-1] != db_r[OPW-1]) && (cmp_calc != C_EQ)) begin
      cmp_calc = (cmp_calc == C_AGT) ? C_BGT : C_AGT;
    end
  end

  always_comb begin
    num_mag  = '0;
    num_neg  = 1'b0;
    den_mag  = '0;
    den_neg  = 1'b0;
    form_err = 1'b1;
    unique case (func_r) inside
      F_ADD, F_SUB: begin
        num_mag  = sum_mag;
        num_neg  = sum_neg;
        den_mag  = p2_r;
        den_neg  = da_r[OPW-1] ^ db_r[OPW-1];
        form_err = (p2_r == '0);
      end
      F_MUL: begin
        num_mag  = p0_r;
        num_neg  = s0;
        den_mag  = p2_r;
        den_neg  = da_r[OPW-1] ^ db_r[OPW-1];
        form_err = (p2_r == '0);
      end
      F_DIV: begin
        num_mag  = p0_r;
        num_neg  = s0;
        den_mag  = p2_r;
        den_neg  = da_r[OPW-1] ^ nb_r[OPW-1];
        form_err = (p2_r == '0) || (db_r == '0);
      end
      F_CMP: begin
        form_err = (da_r == '0) || (db_r == '0);
      end
      F_SIMP: begin
        num_mag  = VW'(pass_r ? mag_nb : mag_na);
        num_neg  = pass_r ? nb_r[OPW-1] : na_r[OPW-1];
        den_mag  = VW'(pass_r ? mag_db : mag_da);
        den_neg  = pass_r ? db_r[OPW-1] : da_r[OPW-1];
        form_err = pass_r ? (db_r == '0) : (da_r == '0);
      end
      default: begin
        form_err = 1'b1;
      end
    endcase
  end

  assign is_last = !((func_r == F_SIMP) && !pass_r);

  always_comb begin
    state_nxt = state_r;
    gcd_start = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (in_func == F_ADD || in_func == F_SUB || in_func == F_DIV ||
                       in_func == F_MUL || in_func == F_CMP) ? S_MUL : S_FORM;
        end
      end
      S_MUL: begin
        if (mcnt_r == 2'd3) begin
          state_nxt = S_FORM;
        end
      end
      S_FORM: begin
        if (form_err || (func_r == F_CMP)) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_GCD;
          gcd_start = 1'b1;
        end
      end
      S_GCD: begin
        if (gcd_done) begin
          state_nxt = S_DIVN;
          div_start = 1'b1;
        end
      end
      S_DIVN: begin
        if (div_done) begin
          state_nxt = S_DIVD;
          div_start = 1'b1;
        end
      end
      S_DIVD: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        state_nxt = is_last ? S_IDLE : S_FORM;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
      mcnt_r       <= '0;
      pass_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == S_OUT);
      if (state_r == S_IDLE) begin
        mcnt_r <= '0;
        pass_r <= 1'b0;
      end else if (state_r == S_MUL) begin
        mcnt_r <= mcnt_r + 1'b1;
      end else if (state_r == S_OUT) begin
        pass_r <= 1'b1;
      end
    end
  end

  // output field conversion
  always_comb begin
    num_ext = {1'b0, nmag_r};
    num_fld = nneg_r ? (~num_ext + 1'b1) : num_ext;
    den_fld = dneg_r ? (~dmag_r + 1'b1) : dmag_r;
    if (err_r) begin
      num_fld = '0;
      den_fld = '0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && start) begin
      func_r <= in_func;
      na_r   <= in_num_a;
      da_r   <= in_den_a;
      nb_r   <= in_num_b;
      db_r   <= in_den_b;
    end
    if (state_r == S_MUL) begin
      case (mcnt_r)
        2'd1:    p0_r <= mul_p;
        2'd2:    p1_r <= mul_p;
        2'd3:    p2_r <= mul_p;
        default: ;
      endcase
    end
    if (state_r == S_FORM) begin
      nmag_r <= num_mag;
      nneg_r <= num_neg;
      dmag_r <= den_mag;
      dneg_r <= den_neg;
      err_r  <= form_err;
      cmp_r  <= (!form_err && (func_r == F_CMP)) ? cmp_calc : C_EQ;
    end
    if ((state_r == S_DIVN) && div_done) begin
      nmag_r <= div_q;
    end
    if ((state_r == S_DIVD) && div_done) begin
      dmag_r <= div_q;
    end
    if (state_r == S_OUT) begin
      out_res_num_r  <= RES_NUM_W'(num_fld);
      out_res_den_r  <= RES_DEN_W'(den_fld);
      out_cmp_code_r <= cmp_r;
      out_error_r    <= err_r;
      out_last_r     <= is_last;
    end
  end

  assign busy         = (state_r != S_IDLE);
  assign out_strobe   = out_strobe_r;
  assign out_res_num  = out_res_num_r;
  assign out_res_den  = out_res_den_r;
  assign out_cmp_code = out_cmp_code_r;
  assign out_error    = out_error_r;
  assign out_last     = out_last_r;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_strobe_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == S_OUT))
    else $error("result strobe outside output state");

  a_gcd_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    gcd_done |-> (state_r == S_GCD))
    else $error("gcd finished while sequencer not waiting");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVN || state_r == S_DIVD))
    else $error("divider finished while sequencer not waiting");
`endif

endmodule
`default_nettype wire

>>> dv/rational_arith_unit_tb.sv
module rational_arith_unit_tb;
  import rau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STUCK_LIMIT = 4000;
  localparam int TAIL_CYCLES = 300;
  localparam int N_RANDOM    = 850;

  typedef enum logic [FUNC_W-1:0] {
    OP_ADD  = F_ADD,
    OP_SUB  = F_SUB,
    OP_DIV  = F_DIV,
    OP_MUL  = F_MUL,
    OP_CMP  = F_CMP,
    OP_SIMP = F_SIMP,
    OP_BAD6 = 3'd6,
    OP_BAD7 = 3'd7
  } op_e;

  typedef enum logic [CMP_W-1:0] {
    CMP_EQ   = C_EQ,
    CMP_A_GT = C_AGT,
    CMP_B_GT = C_BGT
  } cmp_e;

  typedef struct {
    op_e                   func;
    logic signed [OPW-1:0] na;
    logic signed [OPW-1:0] da;
    logic signed [OPW-1:0] nb;
    logic signed [OPW-1:0] db;
    bit                    drain;
  } word_t;

  typedef struct {
    logic signed [RES_NUM_W-1:0] num;
    logic signed [RES_DEN_W-1:0] den;
    cmp_e                        cmp;
    logic                        err;
    logic                        last;
  } frac_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [FUNC_W-1:0]     in_func = '0;
  logic signed [OPW-1:0] in_num_a = '0;
  logic signed [OPW-1:0] in_den_a = '0;
  logic signed [OPW-1:0] in_num_b = '0;
  logic signed [OPW-1:0] in_den_b = '0;
  logic                        out_strobe;
  logic signed [RES_NUM_W-1:0] out_res_num;
  logic signed [RES_DEN_W-1:0] out_res_den;
  logic [CMP_W-1:0]            out_cmp_code;
  logic                        out_error;
  logic                        out_last;

  word_t pending_words[$];
  frac_t due_fracs[$];
  int    op_seen[8];
  int    mismatches    = 0;
  int    words_checked = 0;
  int    stuck         = 0;
  int    burst_left    = 1;
  int    gap_left      = 0;

  rational_arith_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_func     (in_func),
    .in_num_a    (in_num_a),
    .in_den_a    (in_den_a),
    .in_num_b    (in_num_b),
    .in_den_b    (in_den_b),
    .out_strobe  (out_strobe),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den),
    .out_cmp_code(out_cmp_code),
    .out_error   (out_error),
    .out_last    (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint gcd_mag(longint a, longint b);
    longint t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // zero denominator gives the error word
  function automatic frac_t reduce_frac(longint n, longint d, logic last);
    frac_t  r;
    longint g;
    r.num  = '0;
    r.den  = '0;
    r.cmp  = CMP_EQ;
    r.err  = 1'b0;
    r.last = last;
    if (d == 0) begin
      r.err = 1'b1;
    end else begin
      g = gcd_mag(n < 0 ? -n : n, d < 0 ? -d : d);
      r.num = n / g;
      r.den = d / g;
    end
    return r;
  endfunction

  function automatic void rational_predict(word_t w);
    longint na, da, nb, db, x, y;
    frac_t  r;
    na = w.na;
    da = w.da;
    nb = w.nb;
    db = w.db;
    case (w.func)
      OP_ADD:  due_fracs.push_back(reduce_frac(na * db + nb * da, da * db, 1'b1));
      OP_SUB:  due_fracs.push_back(reduce_frac(na * db - nb * da, da * db, 1'b1));
      OP_MUL:  due_fracs.push_back(reduce_frac(na * nb, da * db, 1'b1));
      OP_DIV: begin
        if (da == 0 || db == 0) due_fracs.push_back(reduce_frac(0, 0, 1'b1));
        else due_fracs.push_back(reduce_frac(na * db, da * nb, 1'b1));
      end
      OP_CMP: begin
        if (da == 0 || db == 0) begin
          due_fracs.push_back(reduce_frac(0, 0, 1'b1));
        end else begin
          r = reduce_frac(0, 1, 1'b1);
          r.den = '0;
          x = na * db;
          y = nb * da;
          r.cmp = (x == y) ? CMP_EQ : (x > y) ? CMP_A_GT : CMP_B_GT;
          // negative product of denominators flips the order
          if ((da < 0) != (db < 0) && r.cmp != CMP_EQ)
            r.cmp = (r.cmp == CMP_A_GT) ? CMP_B_GT : CMP_A_GT;
          due_fracs.push_back(r);
        end
      end
      OP_SIMP: begin
        due_fracs.push_back(reduce_frac(na, da, 1'b0));
        due_fracs.push_back(reduce_frac(nb, db, 1'b1));
      end
      default: due_fracs.push_back(reduce_frac(0, 0, 1'b1));
    endcase
  endfunction

  function automatic void add_word(op_e f, int na, int da, int nb, int db, bit drain);
    word_t w;
    w.func  = f;
    w.na    = OPW'(na);
    w.da    = OPW'(da);
    w.nb    = OPW'(nb);
    w.db    = OPW'(db);
    w.drain = drain;
    pending_words.push_back(w);
  endfunction

  function automatic int rand_field(int zero_pct);
    int v;
    if ($urandom_range(0, 99) < zero_pct) return 0;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = -32767;
          2: v = -1;
          3: v = 1;
          default: v = 32767;
        endcase
      end
      1, 2, 3: v = int'($urandom_range(0, 48)) - 24;
      4: v = (int'($urandom_range(0, 30)) - 15) << $urandom_range(0, 10);
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return v;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 5) == 0) return $urandom_range(30, 300);
    return $urandom_range(1, 12);
  endfunction

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    bit fire;
    fire = start && !busy;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (fire) begin
        rational_predict(pending_words[0]);
        op_seen[int'(pending_words[0].func)]++;
        void'(pending_words.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = pick_gap();
        end
      end
      if (!start || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_words.size() == 0) begin
          start <= 1'b0;
        end else if (pending_words[0].drain && (due_fracs.size() != 0 || out_strobe)) begin
          start <= 1'b0;
        end else begin
          start    <= 1'b1;
          in_func  <= pending_words[0].func;
          in_num_a <= pending_words[0].na;
          in_den_a <= pending_words[0].da;
          in_num_b <= pending_words[0].nb;
          in_den_b <= pending_words[0].db;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    frac_t want;
    if (rst_n && out_strobe) begin
      if (due_fracs.size() == 0) begin
        $error("result word with nothing expected: num %0d den %0d",
               out_res_num, out_res_den);
        mismatches++;
      end else begin
        want = due_fracs.pop_front();
        check_field("res_num", want.num, out_res_num);
        check_field("res_den", want.den, out_res_den);
        check_field("cmp_code", want.cmp, out_cmp_code);
        check_field("error", want.err, out_error);
        check_field("last", want.last, out_last);
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) stuck <= 0;
    else stuck <= stuck + 1;
  end

  initial begin
    int f;
    add_word(OP_ADD, 1, 2, 1, 3, 1'b0);
    add_word(OP_SUB, 1, 2, 1, 2, 1'b0);
    add_word(OP_SUB, 3, -4, -3, 4, 1'b0);
    add_word(OP_MUL, -32768, -32768, -32768, -32768, 1'b0);
    add_word(OP_ADD, -32768, -32768, -32768, -32768, 1'b0);
    add_word(OP_ADD, 32767, -32768, 32767, 1, 1'b0);
    add_word(OP_SUB, -32768, 1, 32767, 1, 1'b0);
    add_word(OP_MUL, 32767, -1, -32768, 1, 1'b0);
    add_word(OP_DIV, 3, 4, 0, 5, 1'b0);
    add_word(OP_DIV, 3, 4, 5, 0, 1'b0);
    add_word(OP_DIV, -6, 4, 9, -2, 1'b0);
    add_word(OP_DIV, -32768, -32768, -32768, -32768, 1'b0);
    add_word(OP_ADD, 1, 0, 1, 2, 1'b0);
    add_word(OP_MUL, 0, 5, 7, 0, 1'b0);
    add_word(OP_MUL, 0, -7, 3, 5, 1'b0);
    add_word(OP_CMP, 1, 2, 2, 4, 1'b0);
    add_word(OP_CMP, 1, 2, 1, 3, 1'b0);
    add_word(OP_CMP, 1, -2, 1, 3, 1'b0);
    add_word(OP_CMP, 1, 2, 1, 0, 1'b0);
    add_word(OP_CMP, -32768, 32767, 32767, -32768, 1'b0);
    add_word(OP_SIMP, 6, -8, 0, 0, 1'b0);
    add_word(OP_SIMP, 0, 0, -32768, -32768, 1'b0);
    add_word(OP_SIMP, 0, -9, 32767, 32767, 1'b0);
    add_word(OP_BAD6, 5, 7, -3, 2, 1'b0);
    add_word(OP_BAD7, -32768, 32767, 0, 0, 1'b0);
    for (int i = 0; i < N_RANDOM; i++) begin
      f = $urandom_range(0, 39);
      f = (f < 38) ? f % 6 : f - 32;
      add_word(op_e'(f), rand_field(5), rand_field(4), rand_field(5), rand_field(4),
               i == 0 || i == 300 || i == 600);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while ((pending_words.size() != 0 || due_fracs.size() != 0) && stuck < STUCK_LIMIT)
      @(posedge clk);
    if (stuck < STUCK_LIMIT) repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: add %0d sub %0d div %0d mul %0d cmp %0d simplify %0d bad code %0d",
             op_seen[OP_ADD], op_seen[OP_SUB], op_seen[OP_DIV], op_seen[OP_MUL],
             op_seen[OP_CMP], op_seen[OP_SIMP], op_seen[OP_BAD6] + op_seen[OP_BAD7]);
    $display("summary: %0d result words checked, %0d mismatches, %0d still expected",
             words_checked, mismatches, due_fracs.size());
    if (stuck >= STUCK_LIMIT || due_fracs.size() != 0) begin
      $display("tb: failure");
    end else if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
